### rtl/lcdseq_pkg.sv
// Shared types, constants and the initialization table of the character LCD bus sequencer.
package lcdseq_pkg;

  localparam int COLUMNS_DEF = 20;
  localparam int ROWS_DEF    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int INIT_LEN    = 11;
  localparam int STEP_W      = $clog2(INIT_LEN);

  localparam logic [7:0]  STROBE_RESET  = 8'd50;
  localparam logic [7:0]  CMD_DDRAM     = 8'h80;
  localparam logic [6:0]  ROW_OFF_BIT0  = 7'h40;
  localparam logic [6:0]  ROW_OFF_BIT1  = 7'h14;
  localparam logic [13:0] WAIT_CURSOR   = 14'd400;
  localparam logic [13:0] WAIT_PUTCHAR  = 14'd500;

  typedef enum logic [2:0] {
    KIND_CMD       = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_CURSOR    = 3'd2,
    KIND_PUTCHAR   = 3'd3,
    KIND_INIT      = 3'd4,
    KIND_BACKLIGHT = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PUTCHAR = 2'd1,
    OP_INIT    = 2'd2,
    OP_STATUS  = 2'd3
  } op_t;

  // One classified request, as queued between front and back.
  typedef struct packed {
    op_t         op;
    logic        rs;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [13:0] wait_us;
    logic        err;
    logic        bl_set;
    logic        bl_val;
  } job_t;

  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd1, 4'd2: b = 8'h30;
      4'd3:    b = 8'h38;
      4'd4:    b = 8'h08;
      4'd5:    b = 8'h01;
      4'd6:    b = 8'h06;
      4'd7:    b = 8'h80;
      4'd8:    b = 8'h0C;
      4'd9:    b = 8'h02;
      4'd10:   b = 8'h40;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [13:0] init_wait(input logic [STEP_W-1:0] idx);
    logic [13:0] w;
    case (idx)
      4'd0:       w = 14'd10000;
      4'd1, 4'd2: w = 14'd500;
      4'd9:       w = 14'd2000;
      default:    w = 14'd1000;
    endcase
    return w;
  endfunction

endpackage

### rtl/lcdseq_front.sv
// Request front end: checks the position, maps it to a DDRAM address and queues a job.
module lcdseq_front #(
  parameter int Columns = lcdseq_pkg::COLUMNS_DEF,
  parameter int Rows    = lcdseq_pkg::ROWS_DEF
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic [4:0]        in_column,
  input  logic [2:0]        in_row,
  input  logic              in_backlight_on,
  input  logic              q_full,
  output logic              q_push,
  output lcdseq_pkg::job_t  q_job
);

  logic       bad_pos;
  logic [6:0] addr;
  logic [7:0] ddram_cmd;
  logic       known;

  assign bad_pos = (in_column >= 5'(Columns)) || (in_row >= 3'(Rows));
  assign addr    = {2'b00, in_column}
                 + (in_row[1] ? lcdseq_pkg::ROW_OFF_BIT1 : 7'd0)
                 + (in_row[0] ? lcdseq_pkg::ROW_OFF_BIT0 : 7'd0);
  assign ddram_cmd = lcdseq_pkg::CMD_DDRAM | {1'b0, addr};

  always_comb begin
    q_job         = '0;
    q_job.op      = lcdseq_pkg::OP_STATUS;
    known         = 1'b1;
    case (lcdseq_pkg::kind_t'(in_kind))
      lcdseq_pkg::KIND_CMD: begin
        q_job.op     = lcdseq_pkg::OP_WRITE;
        q_job.byte_a = in_data_byte;
      end
      lcdseq_pkg::KIND_DATA: begin
        q_job.op     = lcdseq_pkg::OP_WRITE;
        q_job.rs     = 1'b1;
        q_job.byte_a = in_data_byte;
      end
      lcdseq_pkg::KIND_CURSOR: begin
        if (bad_pos) begin
          q_job.err = 1'b1;
        end else begin
          q_job.op      = lcdseq_pkg::OP_WRITE;
          q_job.byte_a  = ddram_cmd;
          q_job.wait_us = lcdseq_pkg::WAIT_CURSOR;
        end
      end
      lcdseq_pkg::KIND_PUTCHAR: begin
        if (bad_pos) begin
          q_job.err = 1'b1;
        end else begin
          q_job.op     = lcdseq_pkg::OP_PUTCHAR;
          q_job.byte_a = ddram_cmd;
          q_job.byte_b = in_data_byte;
        end
      end
      lcdseq_pkg::KIND_INIT: begin
        q_job.op = lcdseq_pkg::OP_INIT;
      end
      lcdseq_pkg::KIND_BACKLIGHT: begin
        q_job.bl_set = 1'b1;
        q_job.bl_val = in_backlight_on;
      end
      default: begin
        known = 1'b0;   // unknown kinds are taken and dropped
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && known;

endmodule

### rtl/lcdseq_queue.sv
// Short job queue between the front end and the bus write sequencer.
module lcdseq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcdseq_pkg::job_t  push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output lcdseq_pkg::job_t  head_job
);

  localparam int Depth = lcdseq_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lcdseq_pkg::job_t  slots_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign head_job  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth)) else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

### rtl/lcdseq_back.sv
// Bus write sequencer: expands jobs to descriptors, one per cycle unless stalled.
module lcdseq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  lcdseq_pkg::job_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_bus_write,
  output logic              out_register_select,
  output logic [7:0]        out_bus_byte,
  output logic [13:0]       out_wait_us,
  output logic              out_position_error,
  output logic              out_backlight,
  output logic              out_last
);

  localparam int StepW = lcdseq_pkg::STEP_W;

  logic [StepW-1:0] step_r, step_nxt;
  logic             backlight_r, backlight_nxt;
  logic             valid_r, valid_nxt;
  logic             wr_r, rs_r, err_r, bl_r, last_r;
  logic [7:0]       byte_r;
  logic [13:0]      wait_r;

  logic             load;
  logic             last_step;
  logic             res_wr, res_rs, res_err, res_bl;
  logic [7:0]       res_byte;
  logic [13:0]      res_wait;

  always_comb begin
    last_step = 1'b1;
    res_wr    = 1'b1;
    res_rs    = 1'b0;
    res_byte  = 8'h00;
    res_wait  = 14'd0;
    res_err   = 1'b0;
    res_bl    = backlight_r;
    case (q_head.op)
      lcdseq_pkg::OP_WRITE: begin
        res_rs   = q_head.rs;
        res_byte = q_head.byte_a;
        res_wait = q_head.wait_us;
      end
      lcdseq_pkg::OP_PUTCHAR: begin
        // address write first, then the character
        last_step = (step_r != '0);
        res_rs    = last_step;
        res_byte  = last_step ? q_head.byte_b : q_head.byte_a;
        res_wait  = last_step ? lcdseq_pkg::WAIT_PUTCHAR : lcdseq_pkg::WAIT_CURSOR;
      end
      lcdseq_pkg::OP_INIT: begin
        last_step = (step_r == StepW'(lcdseq_pkg::INIT_LEN - 1));
        res_byte  = lcdseq_pkg::init_byte(step_r);
        res_wait  = lcdseq_pkg::init_wait(step_r);
      end
      lcdseq_pkg::OP_STATUS: begin
        res_wr  = 1'b0;
        res_err = q_head.err;
        res_bl  = q_head.bl_set ? q_head.bl_val : backlight_r;
      end
      default: begin
        res_wr = 1'b0;
      end
    endcase
  end

  assign load  = q_not_empty && (!valid_r || out_ready);
  assign q_pop = load && last_step;

  always_comb begin
    step_nxt      = step_r;
    backlight_nxt = backlight_r;
    valid_nxt     = valid_r;
    if (load) begin
      valid_nxt     = 1'b1;
      step_nxt      = last_step ? '0 : step_r + 1'b1;
      backlight_nxt = res_bl;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      backlight_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      backlight_r <= backlight_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr_r   <= res_wr;
      rs_r   <= res_rs;
      byte_r <= res_byte;
      wait_r <= res_wait;
      err_r  <= res_err;
      bl_r   <= res_bl;
      last_r <= last_step;
    end
  end

  assign out_valid           = valid_r;
  assign out_bus_write       = wr_r;
  assign out_register_select = rs_r;
  assign out_bus_byte        = byte_r;
  assign out_wait_us         = wait_r;
  assign out_position_error  = err_r;
  assign out_backlight       = bl_r;
  assign out_last            = last_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= StepW'(lcdseq_pkg::INIT_LEN - 1)) else $error("step counter overrun");
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !wr_r) |-> (byte_r == 8'h00 && wait_r == 14'd0 && !rs_r && last_r))
    else $error("status item carries write fields");
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && err_r) |-> !wr_r) else $error("position error on a write");
  a_bl_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (bl_r == backlight_r)) else $error("shown backlight differs from state");

endmodule

### rtl/char_lcd_bus_sequencer.sv
// Top level of the character LCD bus sequencer: front end, job queue and write sequencer.
//
//  channel  | direction | handshake            | payload
//  in_      | input     | in_tvalid/in_tready  | tuser kind, tdata request fields
//  out_     | output    | out_tvalid/tready    | tuser bus_write, tdata descriptor, tlast
//  cfg_     | input     | cfg_valid/cfg_ready  | cfg_data strobe_phase_us
//
// Each result item leaves the output register one per cycle while out_tready is high; a request
// gives 1, 2 or 11 descriptors, set by the step counter of the write sequencer.
// Requests are taken every cycle while the two-entry job queue has room, also while
// an output item waits. rst_n (synchronous) empties the queue, turns the backlight off
// and sets the strobe width to 50. Unknown kinds are taken and give no item.
module char_lcd_bus_sequencer #(
  parameter int COLUMNS = lcdseq_pkg::COLUMNS_DEF,
  parameter int ROWS    = lcdseq_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] kind
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [12:8] column, [15:13] row,
                                  // [16] backlight_on, [23:17] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] bus_write
  output logic [31:0] out_tdata,  // [0] register_select, [8:1] bus_byte, [22:9] wait_us,
                                  // [23] position_error, [24] backlight, [31:25] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic              q_push, q_pop, q_full, q_not_empty;
  lcdseq_pkg::job_t  q_job, q_head;
  logic [7:0]        strobe_phase_us_r, strobe_phase_us_nxt;
  logic              rs, pos_err, bl;
  logic [7:0]        bus_byte;
  logic [13:0]       wait_us;

  // strobe width is held for the bus driver; it does not change any result item
  assign cfg_ready           = 1'b1;
  assign strobe_phase_us_nxt = (cfg_valid && cfg_ready) ? cfg_data : strobe_phase_us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_phase_us_r <= lcdseq_pkg::STROBE_RESET;
    end else begin
      strobe_phase_us_r <= strobe_phase_us_nxt;
    end
  end

  lcdseq_front #(
    .Columns (COLUMNS),
    .Rows    (ROWS)
  ) u_front (
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_kind         (in_tuser),
    .in_data_byte    (in_tdata[7:0]),
    .in_column       (in_tdata[12:8]),
    .in_row          (in_tdata[15:13]),
    .in_backlight_on (in_tdata[16]),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job)
  );

  lcdseq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (q_head)
  );

  lcdseq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_bus_write       (out_tuser),
    .out_register_select (rs),
    .out_bus_byte        (bus_byte),
    .out_wait_us         (wait_us),
    .out_position_error  (pos_err),
    .out_backlight       (bl),
    .out_last            (out_tlast)
  );

  assign out_tdata = {7'd0, bl, pos_err, wait_us, bus_byte, rs};

  a_strobe_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (strobe_phase_us_r == lcdseq_pkg::STROBE_RESET))
    else $error("strobe width not restored by reset");

endmodule
